// ----- hw/rtl/lcfr_pkg.sv -----
// Shared types and codes for the LED command frame receiver.
// No dependencies; imported by lcfr_exec and led_command_frame_receiver_top.
package lcfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 16;

  localparam logic [ByteW-1:0] PayloadLimitRst = 8'd64;

  localparam logic [ByteW-1:0] CmdLedOn   = 8'd0;
  localparam logic [ByteW-1:0] CmdLedOff  = 8'd1;
  localparam logic [ByteW-1:0] CmdSetRed  = 8'd2;
  localparam logic [ByteW-1:0] CmdSetGrn  = 8'd3;
  localparam logic [ByteW-1:0] CmdSetBlue = 8'd4;

  typedef enum logic [1:0] {
    StDecoded  = 2'd0,
    StCorrupt  = 2'd1,
    StBadCmd   = 2'd2,
    StOverflow = 2'd3
  } status_e;

  // LED register set as seen after a frame.
  typedef struct packed {
    logic             enabled;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } led_t;

  // Request to carry out a command whose checksum matched.
  typedef struct packed {
    logic             apply;
    logic [ByteW-1:0] code;
    logic [ByteW-1:0] operand;
  } exec_req_t;

endpackage

// ----- hw/rtl/led_command_frame_receiver_top.sv -----
// LED command frame receiver, top level. Depends on lcfr_pkg and lcfr_exec.
// Throughput: one byte word per cycle unless a held result is stalled; the
// frame parser state and the result register are updated in the same cycle
// that a byte is taken; a result is valid the cycle after its frame's last byte.
// Reset (rst_ni low, asynchronous): parser waits for a command byte, all sums,
// LED levels and the enable flag clear, and payload_limit returns to 64.
module led_command_frame_receiver_top import lcfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: payload_limit
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Received bytes. tdata[7:0] = rx_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Results. tdata: [7:0] command_code, [15:8] red_level, [23:16] green_level,
  // [31:24] blue_level, [32] leds_enabled, [39:33] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // tuser[1:0] = status
  output logic [1:0]  m_axis_tuser
);

  // Parser phases, one per field within a frame.
  typedef enum logic [2:0] {
    PhCmd   = 3'd0,
    PhLen   = 3'd1,
    PhData  = 3'd2,
    PhSumHi = 3'd3,
    PhSumLo = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  left_q, left_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ByteW-1:0]  sum_hi_q, sum_hi_d;
  logic [ByteW-1:0]  first_q, first_d;
  logic              have_first_q, have_first_d;
  logic [ByteW-1:0]  limit_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [ByteW-1:0]  out_cmd_q;
  led_t              out_led_q;

  logic              accept;
  logic              emit;
  status_e           frame_status;
  status_e           status;
  exec_req_t         exec_req;
  logic              bad_cmd;
  led_t              led_next;
  logic [ByteW-1:0]  b;

  // The result register acts as the output stage: a new byte is taken
  // whenever it is empty or being drained in the same cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  always_comb begin
    phase_d      = phase_q;
    cmd_d        = cmd_q;
    left_d       = left_q;
    sum_d        = sum_q;
    sum_hi_d     = sum_hi_q;
    first_d      = first_q;
    have_first_d = have_first_q;
    emit         = 1'b0;
    frame_status = StDecoded;
    exec_req     = '{apply: 1'b0, code: cmd_q, operand: first_q};

    if (accept) begin
      case (phase_q)
        PhCmd: begin
          cmd_d        = b;
          sum_d        = {{(SumW-ByteW){1'b0}}, b};
          first_d      = '0;
          have_first_d = 1'b0;
          phase_d      = PhLen;
        end
        PhLen: begin
          if (b > limit_q) begin
            // Oversized frame: report now and treat the next byte as a command.
            emit         = 1'b1;
            frame_status = StOverflow;
            phase_d      = PhCmd;
          end else begin
            left_d  = b;
            phase_d = (b == '0) ? PhSumHi : PhData;
          end
        end
        PhData: begin
          if (!have_first_q) begin
            first_d      = b;
            have_first_d = 1'b1;
          end
          sum_d  = sum_q + {{(SumW-ByteW){1'b0}}, b};
          left_d = left_q - 8'd1;
          if (left_d == '0) begin
            phase_d = PhSumHi;
          end
        end
        PhSumHi: begin
          sum_hi_d = b;
          phase_d  = PhSumLo;
        end
        PhSumLo: begin
          phase_d = PhCmd;
          emit    = 1'b1;
          if ({sum_hi_q, b} != sum_q) begin
            frame_status = StCorrupt;
          end else begin
            exec_req.apply = 1'b1;
          end
        end
        default: begin
          phase_d = PhCmd;
        end
      endcase
    end
  end

  // A frame with a good checksum still reports an unknown command code.
  assign status = (exec_req.apply && bad_cmd) ? StBadCmd : frame_status;

  lcfr_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (exec_req),
    .bad_cmd_o (bad_cmd),
    .led_o     (led_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhCmd;
      cmd_q        <= '0;
      left_q       <= '0;
      sum_q        <= '0;
      sum_hi_q     <= '0;
      first_q      <= '0;
      have_first_q <= 1'b0;
      limit_q      <= PayloadLimitRst;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      cmd_q        <= cmd_d;
      left_q       <= left_d;
      sum_q        <= sum_d;
      sum_hi_q     <= sum_hi_d;
      first_q      <= first_d;
      have_first_q <= have_first_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is loaded only together with valid.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_status_q <= status;
      out_cmd_q    <= cmd_q;
      out_led_q    <= led_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_led_q.enabled, out_led_q.blue,
                          out_led_q.green, out_led_q.red, out_cmd_q};

endmodule

// ----- hw/rtl/lcfr_exec.sv -----
// Command executor: holds the LED brightness registers and the enable flag.
// Depends on lcfr_pkg for command codes and the led_t / exec_req_t types.
module lcfr_exec import lcfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  exec_req_t req_i,
  output logic      bad_cmd_o,
  output led_t      led_o
);

  led_t led_q, led_d;

  always_comb begin
    led_d     = led_q;
    bad_cmd_o = 1'b0;
    case (req_i.code)
      CmdLedOn: begin
        led_d.enabled = 1'b1;
      end
      CmdLedOff: begin
        led_d.red   = '0;
        led_d.green = '0;
        led_d.blue  = '0;
      end
      CmdSetRed: begin
        led_d.red = req_i.operand;
      end
      CmdSetGrn: begin
        led_d.green = req_i.operand;
      end
      CmdSetBlue: begin
        led_d.blue = req_i.operand;
      end
      default: begin
        bad_cmd_o = 1'b1;
      end
    endcase
    if (!req_i.apply) begin
      led_d = led_q;
    end
  end

  // The next value is handed out so the result carries the state after the frame.
  assign led_o = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else begin
      led_q <= led_d;
    end
  end

endmodule
